// ----- hw/rtl/skdh_pkg.sv -----
// ----------------------------------------------------------------------------
// skdh_pkg
// Shared types and constants for the string key dual hasher.
// ----------------------------------------------------------------------------
package skdh_pkg;

    localparam int unsigned KEY_W      = 8;
    localparam int unsigned HASH_W     = 32;
    localparam int unsigned CODE_W     = 31;
    localparam int unsigned TSIZE_W    = 24;
    localparam int unsigned DIV_STEPS  = CODE_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [HASH_W-1:0]    RS_STEP_FACTOR   = 32'd378551;
    localparam logic [HASH_W-1:0]    RS_MULT_INIT     = 32'd63689;
    localparam logic [HASH_W-1:0]    BKDR_SEED        = 32'd131;
    localparam logic [HASH_W-1:0]    HASH_MASK31      = 32'h7FFF_FFFF;
    localparam logic [TSIZE_W-1:0]   TABLE_SIZE_RESET = 24'd3;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST         = DIV_CNT_W'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIN,
        ST_DIV,
        ST_DONE
    } skdh_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;
        logic finish;
        logic div_step;
        logic out_load;
    } skdh_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_last;
        logic out_full;
    } skdh_status_t;

endpackage

// ----- hw/rtl/skdh_if.sv -----
// ----------------------------------------------------------------------------
// skdh_if
// Valid/ready channels: key words in, hash result words out.
// ----------------------------------------------------------------------------
interface skdh_key_if;
    import skdh_pkg::*;

    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   key_byte;
    logic               byte_present;
    logic               last_byte;

    modport source (output valid, output key_byte, output byte_present,
                    output last_byte, input ready);
    modport sink   (input valid, input key_byte, input byte_present,
                    input last_byte, output ready);
endinterface

interface skdh_result_if;
    import skdh_pkg::*;

    logic               valid;
    logic               ready;
    logic [TSIZE_W-1:0] bucket_index;
    logic [CODE_W-1:0]  bkdr_code;

    modport source (output valid, output bucket_index, output bkdr_code,
                    input ready);
    modport sink   (input valid, input bucket_index, input bkdr_code,
                    output ready);
endinterface

// ----- hw/rtl/string_key_dual_hasher.sv -----
// Timing: a key word without the end mark is folded in when it is accepted;
// the closing word then passes capture, 31 modulo steps and the load, which
// waits while the result register is full. Throughput: 1 word per cycle inside
// a key; a closing word holds intake until the bit-serial modulo unit is done.
// Reset (rst_n, async, active low) clears hashes, sets table_size to 3 and
// empties the result register.
// ----------------------------------------------------------------------------
// string_key_dual_hasher
// Byte-serial RS and BKDR hashing of a key with bucket index output.
// ----------------------------------------------------------------------------
module string_key_dual_hasher (
    input  logic                         clk,
    input  logic                         rst_n,
    skdh_key_if.sink                     key_ch,
    skdh_result_if.source                result_ch,
    input  logic                         cfg_we,
    input  logic [skdh_pkg::TSIZE_W-1:0] cfg_wdata
);
    import skdh_pkg::*;

    skdh_cmd_t    cmd;
    skdh_status_t status;

    // Controller: takes key words while idle, then walks the modulo steps
    // and hands the result to the output register once that is free.
    skdh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_ch.valid),
        .key_last  (key_ch.last_byte),
        .key_ready (key_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: two multiply-accumulate hashes, the remainder unit, and the
    // result register that lets new key words in while a result waits.
    skdh_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .key_byte     (key_ch.key_byte),
        .byte_present (key_ch.byte_present),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (result_ch.valid),
        .out_ready    (result_ch.ready),
        .bucket_index (result_ch.bucket_index),
        .bkdr_code    (result_ch.bkdr_code)
    );

endmodule

// ----- hw/rtl/skdh_ctrl.sv -----
// ----------------------------------------------------------------------------
// skdh_ctrl
// Sequencer: byte intake, end-of-key capture, modulo steps, result hand-off.
// ----------------------------------------------------------------------------
module skdh_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  key_valid,
    input  logic                  key_last,
    output logic                  key_ready,
    input  skdh_pkg::skdh_status_t status,
    output skdh_pkg::skdh_cmd_t    cmd
);
    import skdh_pkg::*;

    skdh_state_t state_reg;
    skdh_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        key_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                key_ready = 1'b1;
                if (key_valid)
                begin
                    cmd.take_byte = 1'b1;
                    if (key_last)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the result register is free
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/skdh_dp.sv -----
// ----------------------------------------------------------------------------
// skdh_dp
// Hash accumulators, table size register, bit-serial modulo, result register.
// ----------------------------------------------------------------------------
module skdh_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  skdh_pkg::skdh_cmd_t           cmd,
    output skdh_pkg::skdh_status_t        status,
    input  logic [skdh_pkg::KEY_W-1:0]    key_byte,
    input  logic                          byte_present,
    input  logic                          cfg_we,
    input  logic [skdh_pkg::TSIZE_W-1:0]  cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [skdh_pkg::TSIZE_W-1:0]  bucket_index,
    output logic [skdh_pkg::CODE_W-1:0]   bkdr_code
);
    import skdh_pkg::*;

    logic [HASH_W-1:0]    rs_accum_reg, rs_accum_next;
    logic [HASH_W-1:0]    rs_mult_reg, rs_mult_next;
    logic [HASH_W-1:0]    bkdr_reg, bkdr_next;
    logic [TSIZE_W-1:0]   table_size_reg;
    logic [CODE_W-1:0]    dvd_reg;
    logic [TSIZE_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CODE_W-1:0]    code_reg;
    logic                 out_valid_reg;
    logic [TSIZE_W-1:0]   bucket_reg;
    logic [CODE_W-1:0]    bkdr_code_reg;

    logic [HASH_W-1:0]    byte_ext;
    logic [TSIZE_W:0]     trial;
    logic                 fits;
    logic [TSIZE_W-1:0]   rem_next;

    assign byte_ext      = {{(HASH_W-KEY_W){key_byte[KEY_W-1]}}, key_byte};
    assign rs_accum_next = rs_accum_reg * rs_mult_reg + byte_ext;
    assign rs_mult_next  = rs_mult_reg * RS_STEP_FACTOR;
    assign bkdr_next     = (bkdr_reg << 7) + (bkdr_reg << 1) + bkdr_reg + byte_ext;

    // restoring division, one quotient bit per step
    assign trial    = {rem_reg, dvd_reg[CODE_W-1]};
    assign fits     = (trial >= {1'b0, table_size_reg});
    assign rem_next = fits ? TSIZE_W'(trial - {1'b0, table_size_reg})
                           : trial[TSIZE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_accum_reg   <= '0;
            rs_mult_reg    <= RS_MULT_INIT;
            bkdr_reg       <= '0;
            table_size_reg <= TABLE_SIZE_RESET;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                table_size_reg <= cfg_wdata;
            end
            if (cmd.finish)
            begin
                rs_accum_reg <= '0;
                rs_mult_reg  <= RS_MULT_INIT;
                bkdr_reg     <= '0;
                cnt_reg      <= '0;
            end
            else if (cmd.take_byte && byte_present)
            begin
                rs_accum_reg <= rs_accum_next;
                rs_mult_reg  <= rs_mult_next;
                bkdr_reg     <= bkdr_next;
            end
            if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            dvd_reg  <= rs_accum_reg[CODE_W-1:0];
            code_reg <= bkdr_reg[CODE_W-1:0];
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[CODE_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            // no bucket exists for a zero table size
            bucket_reg    <= (table_size_reg == '0) ? '0 : rem_reg;
            bkdr_code_reg <= code_reg;
        end
    end

    assign status.div_last = (cnt_reg == DIV_LAST);
    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign bucket_index    = bucket_reg;
    assign bkdr_code       = bkdr_code_reg;

endmodule

// ----- hw/rtl/skdh_checker.sv -----
// ----------------------------------------------------------------------------
// skdh_checker
// Port-level checks for the hasher, bound to the top level.
// ----------------------------------------------------------------------------
module skdh_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         key_valid,
    input logic                         key_ready,
    input logic                         key_last,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [skdh_pkg::TSIZE_W-1:0] bucket_index,
    input logic [skdh_pkg::CODE_W-1:0]  bkdr_code
);
    import skdh_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(bucket_index) && $stable(bkdr_code))
        else $error("result word changed while stalled");

    // a key end holds intake low through the capture state and the first modulo step
    a_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready && key_last |=> !key_ready ##1 !key_ready)
        else $error("key intake resumed before the modulo ran");

    // a new result appears only after intake was held
    a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(key_ready))
        else $error("result appeared without a modulo pass");

endmodule

bind string_key_dual_hasher skdh_checker u_skdh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .key_valid    (key_ch.valid),
    .key_ready    (key_ch.ready),
    .key_last     (key_ch.last_byte),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .bucket_index (result_ch.bucket_index),
    .bkdr_code    (result_ch.bkdr_code)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for string_key_dual_hasher. Key words are driven on the
// valid/ready key channel in random bursts; a local model of the RS and BKDR
// hashes predicts each bucket index and hash code, and every result word is
// compared with the oldest prediction. Table size is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import skdh_pkg::*;

    // Hash constants, kept locally for the predictor
    localparam bit [31:0] RS_FACTOR     = 32'd378551;
    localparam bit [31:0] RS_START_MULT = 32'd63689;
    localparam bit [31:0] BKDR_MULT     = 32'd131;
    localparam bit [31:0] LOW31_MASK    = 32'h7FFF_FFFF;
    localparam bit [TSIZE_W-1:0] TSIZE_AT_RESET = 24'd3;
    localparam bit [TSIZE_W-1:0] TSIZE_MAX      = 24'hFF_FFFF;

    // Cycles to let pass after the last result before touching the register, time
    // enough for a closing word to pass through the modulo unit.
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        bit [TSIZE_W-1:0] bucket;
        bit [CODE_W-1:0]  code;
    } hash_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [TSIZE_W-1:0] cfg_wdata;

    skdh_key_if    key_ch ();
    skdh_result_if result_ch ();

    string_key_dual_hasher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_ch    (key_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Local hash state and register copy
    bit [31:0]        rs_acc;
    bit [31:0]        rs_mul;
    bit [31:0]        bk_acc;
    bit [TSIZE_W-1:0] tbl_size;

    hash_result_t awaited_hashes[$];

    int  fail_count      = 0;
    int  results_checked = 0;
    int  words_sent      = 0;
    int  sizes_written   = 0;
    int  burst_left      = 0;
    bit  sender_gaps     = 1'b1;
    bit  hold_off_req    = 1'b0;

    // ------------------------------------------------------------------------
    // Clock and the run limit
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("timeout: %0d hashes still awaited", awaited_hashes.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: fold one accepted key word into the running hashes, and on
    // the end mark queue the bucket index and hash code, then restart.
    // ------------------------------------------------------------------------
    task automatic clear_hash_state();
        rs_acc = '0;
        rs_mul = RS_START_MULT;
        bk_acc = '0;
    endtask

    task automatic fold_key_word(input bit [KEY_W-1:0] kb, input bit present,
                                 input bit last);
        bit [31:0]    sbyte;
        bit [31:0]    rs31;
        hash_result_t r;
        if (present)
        begin
            // the byte counts as a signed char
            sbyte  = {{24{kb[7]}}, kb};
            rs_acc = rs_acc * rs_mul + sbyte;
            rs_mul = rs_mul * RS_FACTOR;
            bk_acc = bk_acc * BKDR_MULT + sbyte;
        end
        if (last)
        begin
            rs31 = rs_acc & LOW31_MASK;
            // no bucket exists for a zero table size: index reads 0
            r.bucket = (tbl_size != 0) ? TSIZE_W'(rs31 % {8'd0, tbl_size}) : '0;
            r.code   = bk_acc[CODE_W-1:0];
            awaited_hashes.push_back(r);
            clear_hash_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // Key channel: offer one word, hold it until accepted, then maybe idle.
    // ------------------------------------------------------------------------
    task automatic send_word(input bit [KEY_W-1:0] kb, input bit present,
                             input bit last);
        int gap;
        key_ch.valid        <= 1'b1;
        key_ch.key_byte     <= kb;
        key_ch.byte_present <= present;
        key_ch.last_byte    <= last;
        @(posedge clk);
        while (!key_ch.ready)
            @(posedge clk);
        fold_key_word(kb, present, last);
        if (present || last)
            words_sent++;
        if (sender_gaps)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                // end of burst: idle a while, sometimes past a whole modulo run
                burst_left = $urandom_range(0, 24);
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(1, 7);
                key_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait until every predicted hash has come back, then let
    // the modulo unit finish anything that gives no result.
    task automatic settle_block();
        key_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write table_size; only called while the block is idle.
    task automatic write_table_size(input bit [TSIZE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tbl_size = value;
        sizes_written++;
    endtask

    // One random key: mostly well-formed with random bytes, sometimes idle
    // words inside, a separate empty closing word, or a stray noise word.
    task automatic send_random_key(inout int sent);
        int len;
        int i;
        bit close_apart;
        bit [KEY_W-1:0] nb;
        bit np;
        bit nl;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                          : $urandom_range(0, 8);
        close_apart = (len == 0) || ($urandom_range(0, 4) == 0);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_word(KEY_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(KEY_W'($urandom_range(0, 255)), 1'b1,
                      !close_apart && (i == len - 1));
            sent++;
        end
        if (close_apart)
        begin
            send_word(KEY_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            sent++;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            nb = KEY_W'($urandom_range(0, 255));
            np = 1'($urandom_range(0, 1));
            nl = 1'($urandom_range(0, 1));
            send_word(nb, np, nl);
            if (np || nl)
                sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset table size of 3: empty and idle words, byte extremes, sign
    // extension, a key closed by an empty word, idle words inside a key.
    task automatic test_directed_keys();
        send_word(8'h5A, 1'b0, 1'b0);       // idle word: no result
        send_word(8'h00, 1'b0, 1'b1);       // empty key
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h7F, 1'b1, 1'b1);
        send_word(8'h80, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h41, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h42, 1'b1, 1'b0);
        send_word(8'hAA, 1'b0, 1'b1);       // close without a byte
        send_word(8'h01, 1'b1, 1'b0);
        send_word(8'hFE, 1'b1, 1'b1);
        settle_block();
    endtask

    // Largest table, a single bucket, and a zero size.
    task automatic test_table_size_extremes();
        write_table_size(TSIZE_MAX);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7F, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        settle_block();
        write_table_size(24'd1);
        send_word(8'hC3, 1'b1, 1'b0);
        send_word(8'h3C, 1'b1, 1'b1);
        settle_block();
        write_table_size(24'd0);
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'hAA, 1'b1, 1'b0);
        send_word(8'h99, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        settle_block();
    endtask

    task automatic test_random_keys(input bit [TSIZE_W-1:0] size, input int words);
        int sent;
        sent = 0;
        write_table_size(size);
        while (sent < words)
            send_random_key(sent);
        settle_block();
    endtask

    // Receiver holds off for a long stretch while short keys keep coming at
    // full rate, so the result register fills and the key channel stalls.
    task automatic test_backpressure_fill();
        int sent;
        int len;
        int i;
        sent = 0;
        write_table_size(TSIZE_W'($urandom_range(2, 5000)));
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        while (sent < 60)
        begin
            len = $urandom_range(0, 2);
            for (i = 0; i < len; i++)
                send_word(KEY_W'($urandom_range(0, 255)), 1'b1, i == len - 1);
            if (len == 0)
                send_word(KEY_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            sent += (len == 0) ? 1 : len;
        end
        sender_gaps = 1'b1;
        wait (hold_off_req == 1'b0);
        settle_block();
    endtask

    // Sender stops mid-phase until every hash is back, then carries on.
    task automatic test_drain_pause();
        int sent;
        sent = 0;
        write_table_size(TSIZE_W'($urandom_range(1, 300)));
        while (sent < 40)
            send_random_key(sent);
        settle_block();
        sent = 0;
        while (sent < 40)
            send_random_key(sent);
        settle_block();
    endtask

    // ------------------------------------------------------------------------
    // Result channel: ready follows segments of random stall density, some
    // with no stalls at all; a hold-off request drops ready for a long count.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int seg_len;
        int stall_pct;
        int k;
        result_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                result_ch.ready <= 1'b0;
                for (k = 0; k < HOLD_OFF_CYCLES; k++)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                seg_len = $urandom_range(4, 40);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 80;
                endcase
                repeat (seg_len)
                begin
                    result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
                    @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every accepted result word against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : hash_checker
        hash_result_t want;
        bit bad_bucket;
        bit bad_code;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (awaited_hashes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result bucket=%0d code=%h", $realtime,
                             result_ch.bucket_index, result_ch.bkdr_code);
            end
            else
            begin
                want = awaited_hashes.pop_front();
                results_checked++;
                bad_bucket = (result_ch.bucket_index !== want.bucket);
                bad_code   = (result_ch.bkdr_code !== want.code);
                if (bad_bucket || bad_code)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: mismatch bucket exp %0d got %0d, code exp %h got %h",
                                 $realtime, want.bucket, result_ch.bucket_index,
                                 want.code, result_ch.bkdr_code);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        key_ch.valid        = 1'b0;
        key_ch.key_byte     = '0;
        key_ch.byte_present = 1'b0;
        key_ch.last_byte    = 1'b0;
        tbl_size            = TSIZE_AT_RESET;
        clear_hash_state();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_keys();
        test_table_size_extremes();
        test_random_keys(TSIZE_W'($urandom_range(2, 1000)), 100);
        test_random_keys(TSIZE_MAX, 100);
        test_backpressure_fill();
        test_random_keys(24'd1, 100);
        test_drain_pause();
        test_random_keys(TSIZE_W'($urandom_range(1, TSIZE_MAX)), 100);
        test_random_keys(24'd7, 100);

        // settle_block already waited out the tail; check nothing is left
        settle_block();

        $display("Run covered %0d key words and %0d hash results over %0d table sizes,",
                 words_sent, results_checked, sizes_written);
        $display("including sizes 0, 1 and max, a long receiver hold-off and a drain pause.");
        if (fail_count == 0 && awaited_hashes.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d hashes never arrived", fail_count,
                     awaited_hashes.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/skdh_pkg.sv
hw/rtl/skdh_if.sv
hw/rtl/skdh_ctrl.sv
hw/rtl/skdh_dp.sv
hw/rtl/string_key_dual_hasher.sv
hw/rtl/skdh_checker.sv
tb/tb_top.sv
